@@ hdl/ftds_pkg.sv @@
// Package with the phase codes, register indexes and beat layouts of the flash sequencer.
`timescale 1ns / 1ps

package ftds_pkg;

	// Sequencer phases as shown on the result beat.
	localparam logic [1:0] PH_STOP  = 2'd0;
	localparam logic [1:0] PH_WAIT  = 2'd1;
	localparam logic [1:0] PH_ARMED = 2'd2;
	localparam logic [1:0] PH_FIRE  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_CYCLE_INTERVAL = 3'd0;
	localparam logic [2:0] REG_SHUTTER_PULSE  = 3'd1;
	localparam logic [2:0] REG_FLASH_DELAY    = 3'd2;
	localparam logic [2:0] REG_FLASH_WIDTH    = 3'd3;
	localparam logic [2:0] REG_REARM_DELAY    = 3'd4;
	localparam logic [2:0] REG_CLOSE_AFTER    = 3'd5;
	localparam logic [2:0] REG_WINDOW_CHECK   = 3'd6;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned TICK_W     = 32;

	// Reset value of the shutter pulse register.
	localparam logic [31:0] SHUTTER_PULSE_RST = 32'd1000000;

	// Input beat, highest bit first.
	typedef struct packed {
		logic in_window;
		logic abort;
		logic sensor_hit;
		logic start_req;
	} tick_t;

	// Result beat, highest bit first.
	typedef struct packed {
		logic [1:0] phase;
		logic       flash_on;
		logic       shutter_open;
	} result_t;

endpackage

@@ hdl/flash_trigger_delay_sequencer.sv @@
// Top level of the flash trigger delay sequencer: tick register, update logic, result register.
//
//  channel   | direction | beat contents
//  s_axis    | in        | one microsecond tick: start_req, sensor_hit, abort, in_window
//  m_axis    | out       | state after that tick: shutter_open, flash_on, phase
//  cfg       | in        | register write: index cfg_addr, value cfg_wdata, strobe cfg_wen
//
// One tick beat is taken every cycle unless a stalled result holds it; its result is registered in the result register.
// The whole phase update (counter, deadline compares) sits between the tick register
// and the result register; deadline sums are formed when configuration is written.
// Reset clears the phase, counter, output levels and configuration to their defaults.
// A stalled result beat holds the tick register; a new tick is still taken whenever
// the result register will empty in the same cycle.
`timescale 1ns / 1ps

module flash_trigger_delay_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [0] start_req, [1] sensor_hit, [2] abort, [3] in_window, [7:4] zero
	input  logic [7:0]                      s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [0] shutter_open, [1] flash_on, [3:2] phase, [7:4] zero
	output logic [7:0]                      m_axis_tdata,
	input  logic                            cfg_wen,
	input  logic [ftds_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [ftds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ftds_pkg::*;

	// Configuration and precomputed deadlines.
	logic [TICK_W-1:0] cycle_interval_q;
	logic [TICK_W-1:0] shutter_pulse_q;
	logic [TICK_W-1:0] flash_delay_q;
	logic [TICK_W-1:0] flash_width_q;
	logic [TICK_W-1:0] rearm_delay_q;
	logic              close_after_q;
	logic              window_check_q;
	logic [TICK_W:0]   cycle_end_q;
	logic [TICK_W:0]   off_at_q;
	logic [TICK_W+1:0] reopen_at_q;

	// Sequencer state.
	logic [1:0]        phase_q;
	logic [TICK_W-1:0] elapsed_q;
	logic              shutter_q;
	logic              flash_q;
	logic              flash_done_q;
	logic              close_done_q;
	logic              rearm_done_q;

	// Pipeline.
	logic    valid_s1;
	tick_t   tick_s1;
	logic    valid_s2;
	result_t res_s2;
	logic    advance;

	// Next-state values.
	logic [1:0]        phase_d;
	logic [TICK_W-1:0] elapsed_d;
	logic              shutter_d;
	logic              flash_d;
	logic              flash_done_d;
	logic              close_done_d;
	logic              rearm_done_d;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0000, res_s2};

	// Configuration writes; deadline sums follow writes to the interval, pulse, flash delay and width registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_interval_q <= '0;
			shutter_pulse_q  <= SHUTTER_PULSE_RST;
			flash_delay_q    <= '0;
			flash_width_q    <= '0;
			rearm_delay_q    <= '0;
			close_after_q    <= 1'b0;
			window_check_q   <= 1'b0;
			cycle_end_q      <= {1'b0, SHUTTER_PULSE_RST};
			off_at_q         <= '0;
			reopen_at_q      <= {2'b00, SHUTTER_PULSE_RST};
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_CYCLE_INTERVAL: begin
					cycle_interval_q <= cfg_wdata;
					cycle_end_q      <= {1'b0, cfg_wdata} + {1'b0, shutter_pulse_q};
				end
				REG_SHUTTER_PULSE: begin
					shutter_pulse_q <= cfg_wdata;
					cycle_end_q     <= {1'b0, cycle_interval_q} + {1'b0, cfg_wdata};
					reopen_at_q     <= {1'b0, off_at_q} + {2'b00, cfg_wdata};
				end
				REG_FLASH_DELAY: begin
					flash_delay_q <= cfg_wdata;
					off_at_q      <= {1'b0, cfg_wdata} + {1'b0, flash_width_q};
					reopen_at_q   <= {2'b00, cfg_wdata} + {2'b00, flash_width_q}
						+ {2'b00, shutter_pulse_q};
				end
				REG_FLASH_WIDTH: begin
					flash_width_q <= cfg_wdata;
					off_at_q      <= {1'b0, flash_delay_q} + {1'b0, cfg_wdata};
					reopen_at_q   <= {2'b00, flash_delay_q} + {2'b00, cfg_wdata}
						+ {2'b00, shutter_pulse_q};
				end
				REG_REARM_DELAY:    rearm_delay_q  <= cfg_wdata;
				REG_CLOSE_AFTER:    close_after_q  <= cfg_wdata[0];
				REG_WINDOW_CHECK:   window_check_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Phase update for the tick held in the input register.
	always_comb begin
		logic              wait_needed;
		logic              restarted;
		logic [TICK_W-1:0] e;
		logic [TICK_W-1:0] e_inc;
		logic              fd;
		logic              cd;
		logic              rd;

		phase_d      = phase_q;
		elapsed_d    = elapsed_q;
		shutter_d    = shutter_q;
		flash_d      = flash_q;
		flash_done_d = flash_done_q;
		close_done_d = close_done_q;
		rearm_done_d = rearm_done_q;
		wait_needed  = window_check_q && !tick_s1.in_window;
		restarted    = 1'b0;
		fd           = flash_done_q;
		cd           = close_done_q;
		rd           = rearm_done_q;
		e            = elapsed_q;

		// Before firing checks, a hit clears count, flash and rearm done; close done = !close_after.
		if (phase_q == PH_ARMED && tick_s1.sensor_hit) begin
			e  = '0;
			fd = 1'b0;
			cd = !close_after_q;
			rd = 1'b0;
		end
		e_inc = (e == '1) ? e : e + 1'b1;

		if (tick_s1.abort) begin
			phase_d   = PH_STOP;
			elapsed_d = '0;
			shutter_d = 1'b0;
			flash_d   = 1'b0;
		end else if (phase_q == PH_STOP) begin
			if (tick_s1.start_req) begin
				shutter_d = 1'b1;
				flash_d   = 1'b0;
				elapsed_d = '0;
				phase_d   = wait_needed ? PH_WAIT : PH_ARMED;
			end
		end else if (phase_q == PH_WAIT) begin
			if (!wait_needed) begin
				phase_d   = PH_ARMED;
				shutter_d = 1'b1;
				elapsed_d = '0;
			end
		end else if (phase_q == PH_ARMED && !tick_s1.sensor_hit) begin
			if (wait_needed) begin
				phase_d = PH_WAIT;
			end else begin
				// Shutter cycling: close after the interval, reopen after the pulse.
				if (cycle_interval_q != '0 && elapsed_q >= cycle_interval_q) begin
					shutter_d = 1'b0;
					if ({1'b0, elapsed_q} >= cycle_end_q) begin
						shutter_d = 1'b1;
						elapsed_d = '0;
						restarted = 1'b1;
					end
				end
				if (!restarted) begin
					elapsed_d = e_inc;
				end
			end
		end else begin
			// Firing checks, also taken on the hit tick itself.
			phase_d = PH_FIRE;
			if (!fd && e >= flash_delay_q) begin
				flash_d = 1'b1;
				if ({1'b0, e} >= off_at_q) begin
					flash_d = 1'b0;
					fd      = 1'b1;
				end
			end
			if (!cd && {1'b0, e} >= off_at_q) begin
				shutter_d = 1'b0;
				if ({2'b00, e} >= reopen_at_q) begin
					shutter_d = 1'b1;
					cd        = 1'b1;
				end
			end
			if (e >= rearm_delay_q) begin
				rd = 1'b1;
			end
			if (fd && cd && rd) begin
				phase_d   = PH_ARMED;
				elapsed_d = '0;
			end else begin
				elapsed_d = e_inc;
			end
			flash_done_d = fd;
			close_done_d = cd;
			rearm_done_d = rd;
		end
	end

	// Input register: holds a tick until its result can be stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			tick_s1 <= tick_t'(s_axis_tdata[3:0]);
		end
	end

	// Sequencer state advances once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_STOP;
			elapsed_q    <= '0;
			shutter_q    <= 1'b0;
			flash_q      <= 1'b0;
			flash_done_q <= 1'b0;
			close_done_q <= 1'b0;
			rearm_done_q <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_d;
			elapsed_q    <= elapsed_d;
			shutter_q    <= shutter_d;
			flash_q      <= flash_d;
			flash_done_q <= flash_done_d;
			close_done_q <= close_done_d;
			rearm_done_q <= rearm_done_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.shutter_open <= shutter_d;
			res_s2.flash_on     <= flash_d;
			res_s2.phase        <= phase_d;
		end
	end

`ifndef SYNTHESIS
	// The flash only fires inside the firing phase.
	assert property (@(posedge clk) disable iff (!arst_n) flash_q |-> phase_q == PH_FIRE)
		else $error("flash high outside firing phase");

	// Stopped means every output low and the counter cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STOP |-> !shutter_q && !flash_q && elapsed_q == '0)
		else $error("stopped phase with live outputs or counter");

	// An abort tick yields a stopped, all-low result beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && tick_s1.abort |=> valid_s2 && m_axis_tdata == 8'h00)
		else $error("abort did not clear the result");

	// A held tick keeps its contents while the result side stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(tick_s1))
		else $error("tick register lost a pending beat");
`endif

endmodule
